/* src/bandwidth_vote_aggregator_defines.svh */
// Assertion macros
`ifndef BANDWIDTH_VOTE_AGGREGATOR_DEFINES_SVH
`define BANDWIDTH_VOTE_AGGREGATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BVA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define BVA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define BVA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define BVA_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

/* src/bva_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bva_pkg;
	localparam int CLIENTS_D = 8;
	localparam int BUS_KINDS_D = 2;
	localparam int MAX_PORTS_D = 3;
	localparam int MAX_USECASES_D = 16;
	localparam int QW = 48;
	localparam int PW = 53;
	localparam int SW = 64;

	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_SKIPPED = 3'd1;
	localparam logic [2:0] ST_NO_BUS = 3'd2;
	localparam logic [2:0] ST_BAD_CFG = 3'd3;
	localparam logic [2:0] ST_ZERO = 3'd4;

	localparam logic [2:0] REG_BUS = 3'd0;
	localparam logic [2:0] REG_DRAM = 3'd1;
	localparam logic [2:0] REG_PORTS = 3'd2;
	localparam logic [2:0] REG_NRT = 3'd3;
	localparam logic [2:0] REG_UC = 3'd4;

	typedef struct packed {
		logic [2:0] client;
		logic [1:0] kind;
		logic [QW-1:0] avg;
		logic [QW-1:0] inst;
	} vote_t;

	typedef struct packed {
		logic bus_registered;
		logic [3:0] dram_channels;
		logic [1:0] port_count;
		logic [1:0] nrt_port_count;
		logic [4:0] usecase_count;
	} cfg_t;
endpackage
`default_nettype wire

/* src/bva_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// input vote queue
module bva_front #(
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire bva_pkg::vote_t in_vote,
	output logic q_valid,
	input wire logic q_pop,
	output bva_pkg::vote_t q_vote
);
	import bva_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	vote_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == (AW+1)'(DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_vote = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_vote;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (q_pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule
`default_nettype wire

/* src/bva_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module bva_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [bva_pkg::SW-1:0] dividend,
	input wire logic [3:0] divisor,
	output logic busy,
	output logic [bva_pkg::SW-1:0] quotient
);
	import bva_pkg::*;
	logic [SW-1:0] q_q;
	logic [4:0] r_q;
	logic [6:0] n_q;
	logic [4:0] trial;
	logic [3:0] d_q;

	assign trial = {r_q[3:0], q_q[SW-1]};
	assign busy = (n_q != '0);
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (start) begin
			n_q <= 7'(SW);
		end else if (busy) begin
			n_q <= n_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[SW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[SW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

/* src/bva_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// table walk, divisions, compare and result emission
module bva_back #(
	parameter int CLIENTS = bva_pkg::CLIENTS_D,
	parameter int BUS_KINDS = bva_pkg::BUS_KINDS_D,
	parameter int MAX_PORTS = bva_pkg::MAX_PORTS_D,
	parameter int MAX_USECASES = bva_pkg::MAX_USECASES_D
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bva_pkg::cfg_t cfg,
	input wire logic q_valid,
	output logic q_pop,
	input wire bva_pkg::vote_t q_vote,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic [3:0] usecase_index,
	output logic [1:0] port_index,
	output logic [bva_pkg::PW-1:0] port_avg,
	output logic [bva_pkg::PW-1:0] port_inst,
	output logic last
);
	import bva_pkg::*;
	localparam int VOTES = CLIENTS * BUS_KINDS;
	localparam int VW = (VOTES > 1) ? $clog2(VOTES) : 1;
	localparam int KW = $clog2(BUS_KINDS);
	localparam int PIW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_WALK = 8'b00000010,
		S_JUDGE = 8'b00000100,
		S_DIV = 8'b00001000,
		S_DWAIT = 8'b00010000,
		S_CMP = 8'b00100000,
		S_EMIT = 8'b01000000,
		S_ONE = 8'b10000000
	} state_t;

	state_t st_q;
	logic [QW-1:0] avg_mem [VOTES];
	logic [QW-1:0] inst_mem [VOTES];
	logic [VOTES-1:0] vld_q;
	logic [VW:0] idx_q;
	logic [QW-1:0] ra_q, ri_q;
	logic [SW-1:0] avg_rt_q, inst_rt_q, avg_nrt_q, inst_nrt_q;
	logic rd_v_q;
	logic [VW-1:0] rd_i_q;
	logic [1:0] dstep_q;
	logic [PW-1:0] cur_avg_q [MAX_PORTS];
	logic [PW-1:0] cur_inst_q [MAX_PORTS];
	logic [PW-1:0] rt_a_q, rt_i_q, nrt_a_q, nrt_i_q;
	logic [3:0] uc_q;
	logic [2:0] ost_q;
	logic [1:0] port_q;
	logic [1:0] nrt_cnt, rtc;
	logic bad_cfg, all_zero, match;
	logic div_start, div_busy;
	logic [SW-1:0] div_a, div_q;
	logic [3:0] div_d;
	logic [4:0] ucnt;
	logic [4:0] uc_dm1, uc_rem;
	logic [3:0] uc_next;
	logic [VW-1:0] wr_i;
	logic wr_ok;
	logic [1:0] tot;

	bva_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_d), .busy(div_busy), .quotient(div_q)
	);

	assign tot = cfg.port_count;
	assign nrt_cnt = cfg.nrt_port_count;
	assign rtc = tot - nrt_cnt;
	assign bad_cfg = (tot == 2'd0) || (32'(tot) > MAX_PORTS)
		|| (nrt_cnt != 2'd0 && nrt_cnt >= tot);
	assign all_zero = (avg_rt_q == '0) && (inst_rt_q == '0)
		&& (avg_nrt_q == '0) && (inst_nrt_q == '0);
	assign wr_ok = (32'(q_vote.client) < CLIENTS) && (32'(q_vote.kind) < BUS_KINDS);
	assign wr_i = VW'(32'(q_vote.client) * BUS_KINDS + 32'(q_vote.kind));
	assign ucnt = (cfg.usecase_count < 5'd2) ? 5'd2
		: ((32'(cfg.usecase_count) > MAX_USECASES) ? 5'(MAX_USECASES)
		: cfg.usecase_count);
	assign uc_dm1 = ucnt - 5'd1;

	// current slot modulo (count - 1), one compare and subtract per bit
	always_comb begin
		uc_rem = '0;
		for (int b = 3; b >= 0; b--) begin
			uc_rem = {uc_rem[3:0], uc_q[b]};
			if (uc_rem >= uc_dm1) uc_rem = uc_rem - uc_dm1;
		end
	end
	assign uc_next = uc_rem[3:0] + 4'd1;

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < MAX_PORTS; i++) begin
			if (i < 32'(tot)) begin
				if (32'(i) < 32'(rtc) || nrt_cnt == 2'd0) begin
					if (cur_avg_q[i] != rt_a_q || cur_inst_q[i] != rt_i_q) match = 1'b0;
				end else begin
					if (cur_avg_q[i] != nrt_a_q || cur_inst_q[i] != nrt_i_q) match = 1'b0;
				end
			end
		end
	end

	// divider operand order: nrt>0: inst_rt, inst_nrt, avg_rt/rtc, avg_nrt/nrt
	// nrt=0: inst_rt, inst_nrt, (avg_rt+avg_nrt)/tot
	always_comb begin
		div_a = inst_rt_q;
		div_d = cfg.dram_channels;
		unique case (dstep_q)
			2'd0: begin div_a = inst_rt_q; div_d = cfg.dram_channels; end
			2'd1: begin div_a = inst_nrt_q; div_d = cfg.dram_channels; end
			2'd2: begin
				div_a = (nrt_cnt != 2'd0) ? avg_rt_q : avg_rt_q + avg_nrt_q;
				div_d = (nrt_cnt != 2'd0) ? {2'b0, rtc} : {2'b0, tot};
			end
			2'd3: begin div_a = avg_nrt_q; div_d = {2'b0, nrt_cnt}; end
			default: ;
		endcase
	end

	assign div_start = (st_q == S_DIV) && !(dstep_q <= 2'd1 && cfg.dram_channels == 4'd0);
	assign q_pop = (st_q == S_IDLE) && q_valid;
	assign out_valid = (st_q == S_EMIT) || (st_q == S_ONE);
	assign status = ost_q;
	assign usecase_index = (ost_q == ST_UPDATED) ? uc_q : 4'd0;
	assign port_index = (ost_q == ST_UPDATED) ? port_q : 2'd0;
	assign last = (st_q == S_ONE) || (port_q == tot - 2'd1);
	always_comb begin
		port_avg = '0;
		port_inst = '0;
		if (ost_q == ST_UPDATED) begin
			port_avg = cur_avg_q[PIW'(port_q)];
			port_inst = cur_inst_q[PIW'(port_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && wr_ok) begin
			avg_mem[wr_i] <= q_vote.avg;
			inst_mem[wr_i] <= q_vote.inst;
		end
		ra_q <= avg_mem[idx_q[VW-1:0]];
		ri_q <= inst_mem[idx_q[VW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vld_q <= '0;
			idx_q <= '0;
			rd_v_q <= 1'b0;
			rd_i_q <= '0;
			dstep_q <= '0;
			uc_q <= '0;
			ost_q <= ST_UPDATED;
			port_q <= '0;
			avg_rt_q <= '0;
			inst_rt_q <= '0;
			avg_nrt_q <= '0;
			inst_nrt_q <= '0;
			rt_a_q <= '0;
			rt_i_q <= '0;
			nrt_a_q <= '0;
			nrt_i_q <= '0;
			for (int i = 0; i < MAX_PORTS; i++) begin
				cur_avg_q[i] <= '0;
				cur_inst_q[i] <= '0;
			end
		end else begin
			unique case (st_q)
				S_IDLE: if (q_valid) begin
					if (wr_ok) vld_q[wr_i] <= 1'b1;
					idx_q <= '0;
					rd_v_q <= 1'b0;
					avg_rt_q <= '0;
					inst_rt_q <= '0;
					avg_nrt_q <= '0;
					inst_nrt_q <= '0;
					st_q <= S_WALK;
				end
				S_WALK: begin
					if (idx_q != (VW+1)'(VOTES)) idx_q <= idx_q + 1'b1;
					rd_v_q <= (idx_q != (VW+1)'(VOTES));
					rd_i_q <= idx_q[VW-1:0];
					if (rd_v_q && vld_q[rd_i_q]) begin
						if (KW'(rd_i_q) == KW'(1)) begin
							avg_nrt_q <= avg_nrt_q + SW'(ra_q);
							inst_nrt_q <= inst_nrt_q + SW'(ri_q);
						end else begin
							avg_rt_q <= avg_rt_q + SW'(ra_q);
							if (SW'(ri_q) > inst_rt_q) inst_rt_q <= SW'(ri_q);
						end
					end
					if (!rd_v_q && idx_q == (VW+1)'(VOTES)) st_q <= S_JUDGE;
				end
				S_JUDGE: begin
					dstep_q <= 2'd0;
					if (!cfg.bus_registered) begin
						ost_q <= ST_NO_BUS;
						st_q <= S_ONE;
					end else if (all_zero) begin
						ost_q <= ST_ZERO;
						uc_q <= '0;
						for (int i = 0; i < MAX_PORTS; i++) begin
							cur_avg_q[i] <= '0;
							cur_inst_q[i] <= '0;
						end
						st_q <= S_ONE;
					end else if (bad_cfg) begin
						ost_q <= ST_BAD_CFG;
						st_q <= S_ONE;
					end else begin
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!div_start) begin
						if (dstep_q == 2'd0) inst_rt_q <= inst_rt_q;
						dstep_q <= dstep_q + 2'd1;
					end else begin
						st_q <= S_DWAIT;
					end
				end
				S_DWAIT: if (!div_busy && !div_start) begin
					unique case (dstep_q)
						2'd0: inst_rt_q <= div_q;
						2'd1: inst_nrt_q <= div_q;
						2'd2: avg_rt_q <= div_q;
						2'd3: avg_nrt_q <= div_q;
						default: ;
					endcase
					if (dstep_q == 2'd3 || (dstep_q == 2'd2 && nrt_cnt == 2'd0)) begin
						st_q <= S_CMP;
						dstep_q <= dstep_q;
					end else begin
						dstep_q <= dstep_q + 2'd1;
						st_q <= S_DIV;
					end
				end
				S_CMP: begin
					// loads the per-kind values first, then compares
					if (dstep_q != 2'd0) begin
						rt_a_q <= PW'(avg_rt_q);
						rt_i_q <= (nrt_cnt != 2'd0) ? PW'(inst_rt_q)
							: PW'(inst_rt_q + inst_nrt_q);
						nrt_a_q <= PW'(avg_nrt_q);
						nrt_i_q <= PW'(inst_nrt_q);
						dstep_q <= 2'd0;
					end else if (match) begin
						ost_q <= ST_SKIPPED;
						st_q <= S_ONE;
					end else begin
						uc_q <= uc_next;
						ost_q <= ST_UPDATED;
						port_q <= '0;
						for (int i = 0; i < MAX_PORTS; i++) begin
							if (i >= 32'(tot)) begin
								cur_avg_q[i] <= '0;
								cur_inst_q[i] <= '0;
							end else if (32'(i) < 32'(rtc) || nrt_cnt == 2'd0) begin
								cur_avg_q[i] <= rt_a_q;
								cur_inst_q[i] <= rt_i_q;
							end else begin
								cur_avg_q[i] <= nrt_a_q;
								cur_inst_q[i] <= nrt_i_q;
							end
						end
						st_q <= S_EMIT;
					end
				end
				S_EMIT: if (!out_stall) begin
					if (last) st_q <= S_IDLE;
					else port_q <= port_q + 2'd1;
				end
				S_ONE: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/bandwidth_vote_aggregator.sv */
// channel | handshake                | payload
// vote in | in_valid / in_stall      | client_index bus_kind avg_quota inst_quota
// result  | out_valid / out_stall    | status usecase_index port_index port_avg port_inst last
// config  | cfg_we                   | cfg_index cfg_data
// A vote leaves the queue, then the back end walks the vote table, judges the vote and runs
// the divisions on the shared bit-serial divider (three with no non-realtime port, else four;
// a DRAM division by 0 is skipped), compares, then emits the results one transfer at a time.
// A two-entry queue takes votes while the back end works. Reset clears all control state
// and the vote table valid bits. A stalled result holds until the transfer.
`timescale 1ns / 1ps
`default_nettype none
`include "bandwidth_vote_aggregator_defines.svh"
module bandwidth_vote_aggregator #(
	parameter int CLIENTS = bva_pkg::CLIENTS_D,
	parameter int BUS_KINDS = bva_pkg::BUS_KINDS_D,
	parameter int MAX_PORTS = bva_pkg::MAX_PORTS_D,
	parameter int MAX_USECASES = bva_pkg::MAX_USECASES_D
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [4:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] client_index,
	input wire logic bus_kind,
	input wire logic [bva_pkg::QW-1:0] avg_quota,
	input wire logic [bva_pkg::QW-1:0] inst_quota,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic [3:0] usecase_index,
	output logic [1:0] port_index,
	output logic [bva_pkg::PW-1:0] port_avg,
	output logic [bva_pkg::PW-1:0] port_inst,
	output logic last
);
	import bva_pkg::*;
	cfg_t cfg_q;
	vote_t in_vote, q_vote;
	logic q_valid, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{bus_registered: 1'b1, dram_channels: 4'd1, port_count: 2'd1,
				nrt_port_count: 2'd0, usecase_count: 5'd2};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUS: cfg_q.bus_registered <= cfg_data[0];
				REG_DRAM: cfg_q.dram_channels <= cfg_data[3:0];
				REG_PORTS: cfg_q.port_count <= cfg_data[1:0];
				REG_NRT: cfg_q.nrt_port_count <= cfg_data[1:0];
				REG_UC: cfg_q.usecase_count <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_vote = '{client: client_index, kind: {1'b0, bus_kind},
		avg: avg_quota, inst: inst_quota};

	bva_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_vote(in_vote), .q_valid(q_valid), .q_pop(q_pop), .q_vote(q_vote)
	);

	bva_back #(
		.CLIENTS(CLIENTS), .BUS_KINDS(BUS_KINDS), .MAX_PORTS(MAX_PORTS),
		.MAX_USECASES(MAX_USECASES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_pop(q_pop),
		.q_vote(q_vote), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .usecase_index(usecase_index), .port_index(port_index),
		.port_avg(port_avg), .port_inst(port_inst), .last(last)
	);

	`BVA_ASSERT_IMP(a_pop_valid, clk, arst_n, q_pop, q_valid, "pop of empty queue")
	`BVA_ASSERT_IMP(a_err_last, clk, arst_n, out_valid && status != ST_UPDATED, last, "error not last")
	`BVA_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status), "result dropped")
endmodule
`default_nettype wire

/* tb/bandwidth_vote_aggregator_test.sv */
`timescale 1ns / 1ps
module bandwidth_vote_aggregator_test;
	import bva_pkg::*;

	localparam int VOTE_CYCLES = 400;

	typedef struct {
		logic [2:0] st;
		logic [3:0] uc;
		logic [1:0] port;
		logic [PW-1:0] pavg;
		logic [PW-1:0] pinst;
		logic lst;
	} bw_result_t;

	typedef struct {
		logic [2:0] client;
		logic kind;
		logic [QW-1:0] avg;
		logic [QW-1:0] inst;
		logic known;
		logic [2:0] st;
	} vote_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_BUS;
	logic [4:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] client_index = '0;
	logic bus_kind = 1'b0;
	logic [QW-1:0] avg_quota = '0;
	logic [QW-1:0] inst_quota = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [3:0] usecase_index;
	logic [1:0] port_index;
	logic [PW-1:0] port_avg;
	logic [PW-1:0] port_inst;
	logic last;

	bandwidth_vote_aggregator dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [QW-1:0] tbl_avg [CLIENTS_D*BUS_KINDS_D];
	logic [QW-1:0] tbl_inst [CLIENTS_D*BUS_KINDS_D];
	logic [3:0] cur_uc;
	logic [PW-1:0] cur_avg [MAX_PORTS_D];
	logic [PW-1:0] cur_inst [MAX_PORTS_D];
	cfg_t cfg;

	bw_result_t pending_results[$];
	logic [2:0] known_status[$];
	int errors = 0;
	bit hold_rx = 0;
	bit rx_busy = 0;

	function automatic void aggregate_vote(input logic [2:0] client, input logic kind,
			input logic [QW-1:0] avg, input logic [QW-1:0] inst);
		logic [63:0] art, irt, anrt, inrt;
		logic [63:0] pa [MAX_PORTS_D];
		logic [63:0] pi [MAX_PORTS_D];
		int total, rtc, match_cnt, cnt;
		bw_result_t r;
		art = 0; irt = 0; anrt = 0; inrt = 0;
		tbl_avg[client*2 + kind] = avg;
		tbl_inst[client*2 + kind] = inst;
		for (int i = 0; i < CLIENTS_D*BUS_KINDS_D; i++) begin
			if (i % 2 == 1) begin
				anrt += tbl_avg[i];
				inrt += tbl_inst[i];
			end else begin
				art += tbl_avg[i];
				if (tbl_inst[i] > irt) irt = tbl_inst[i];
			end
		end
		r = '{st: ST_NO_BUS, uc: 0, port: 0, pavg: 0, pinst: 0, lst: 1};
		if (!cfg.bus_registered) begin
			pending_results.push_back(r);
			return;
		end
		if (art == 0 && anrt == 0 && irt == 0 && inrt == 0) begin
			cur_uc = 0;
			for (int i = 0; i < MAX_PORTS_D; i++) begin
				cur_avg[i] = 0;
				cur_inst[i] = 0;
			end
			r.st = ST_ZERO;
			pending_results.push_back(r);
			return;
		end
		total = cfg.port_count;
		if (total == 0 || total > MAX_PORTS_D ||
				(cfg.nrt_port_count != 0 && cfg.nrt_port_count >= total)) begin
			r.st = ST_BAD_CFG;
			pending_results.push_back(r);
			return;
		end
		rtc = total - cfg.nrt_port_count;
		if (cfg.dram_channels != 0) begin
			irt /= cfg.dram_channels;
			inrt /= cfg.dram_channels;
		end
		for (int i = 0; i < MAX_PORTS_D; i++) begin
			pa[i] = 0;
			pi[i] = 0;
		end
		if (cfg.nrt_port_count != 0) begin
			art /= rtc;
			anrt /= cfg.nrt_port_count;
			for (int i = 0; i < total; i++) begin
				pa[i] = (i < rtc) ? art : anrt;
				pi[i] = (i < rtc) ? irt : inrt;
			end
		end else begin
			for (int i = 0; i < total; i++) begin
				pa[i] = (art + anrt) / total;
				pi[i] = irt + inrt;
			end
		end
		match_cnt = 0;
		for (int i = 0; i < total; i++)
			if (pa[i][PW-1:0] == cur_avg[i] && pi[i][PW-1:0] == cur_inst[i]) match_cnt++;
		if (match_cnt == total) begin
			r.st = ST_SKIPPED;
			pending_results.push_back(r);
			return;
		end
		cnt = cfg.usecase_count;
		if (cnt < 2) cnt = 2;
		if (cnt > MAX_USECASES_D) cnt = MAX_USECASES_D;
		cur_uc = 4'((cur_uc % (cnt - 1)) + 1);
		for (int i = 0; i < MAX_PORTS_D; i++) begin
			cur_avg[i] = pa[i][PW-1:0];
			cur_inst[i] = pi[i][PW-1:0];
		end
		for (int i = 0; i < total; i++) begin
			r = '{st: ST_UPDATED, uc: cur_uc, port: i, pavg: pa[i][PW-1:0],
				pinst: pi[i][PW-1:0], lst: (i + 1 == total)};
			pending_results.push_back(r);
		end
	endfunction

	task automatic wait_cycles(input int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BUS: cfg.bus_registered = val[0];
			REG_DRAM: cfg.dram_channels = val[3:0];
			REG_PORTS: cfg.port_count = val[1:0];
			REG_NRT: cfg.nrt_port_count = val[1:0];
			REG_UC: cfg.usecase_count = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic drain_votes();
		wait_results();
		wait_cycles(VOTE_CYCLES);
	endtask

	task automatic send_vote(input logic [2:0] c, input logic k, input logic [QW-1:0] a,
			input logic [QW-1:0] q, input logic known, input logic [2:0] st);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			wait_cycles(gap);
		end
		in_valid <= 1'b1;
		client_index <= c;
		bus_kind <= k;
		avg_quota <= a;
		inst_quota <= q;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (known) known_status.push_back(st);
		else known_status.push_back(3'h7);
		aggregate_vote(c, k, a, q);
	endtask

	function automatic logic [QW-1:0] rand_quota();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return QW'($urandom_range(0, 1000));
			default: return QW'({$urandom(), $urandom()});
		endcase
	endfunction

	// receiver
	always @(posedge clk) begin
		if (out_valid && !out_stall && arst_n) begin
			bw_result_t e;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (e.lst && known_status.size() != 0) begin
					if (known_status[0] != 3'h7 && known_status[0] != status) begin
						$error("status table: expected %0d actual %0d", known_status[0], status);
						errors++;
					end
					void'(known_status.pop_front());
				end
				if (status !== e.st) begin
					$error("status: expected %0d actual %0d", e.st, status); errors++;
				end
				if (usecase_index !== e.uc) begin
					$error("usecase_index: expected %0d actual %0d", e.uc, usecase_index);
					errors++;
				end
				if (port_index !== e.port) begin
					$error("port_index: expected %0d actual %0d", e.port, port_index); errors++;
				end
				if (port_avg !== e.pavg) begin
					$error("port_avg: expected %0h actual %0h", e.pavg, port_avg); errors++;
				end
				if (port_inst !== e.pinst) begin
					$error("port_inst: expected %0h actual %0h", e.pinst, port_inst); errors++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0d actual %0d", e.lst, last); errors++;
				end
			end
		end
	end

	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (1500) @(posedge clk);
				out_stall <= 1'b0;
				hold_rx = 0;
			end else if (rx_busy) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		#(80ms);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	vote_row_t dir_rows[] = '{
		'{0, 0, 0, 0, 1, ST_ZERO},
		'{0, 0, 48'd100, 48'd40, 0, 0},
		'{0, 0, 48'd100, 48'd40, 1, ST_SKIPPED},
		'{7, 1, '1, '1, 0, 0},
		'{7, 1, '1, '1, 1, ST_SKIPPED},
		'{3, 0, '1, 48'd0, 0, 0},
		'{3, 0, 0, 0, 0, 0},
		'{7, 1, 0, 0, 0, 0},
		'{0, 0, 0, 0, 1, ST_ZERO},
		'{5, 1, 48'd7, 48'd9, 0, 0}
	};

	initial begin
		cur_uc = 0;
		for (int i = 0; i < CLIENTS_D*BUS_KINDS_D; i++) begin
			tbl_avg[i] = 0;
			tbl_inst[i] = 0;
		end
		for (int i = 0; i < MAX_PORTS_D; i++) begin
			cur_avg[i] = 0;
			cur_inst[i] = 0;
		end
		cfg = '{bus_registered: 1, dram_channels: 1, port_count: 1,
			nrt_port_count: 0, usecase_count: 2};
		wait_cycles(3);
		arst_n <= 1'b1;
		wait_cycles(2);
		rx_busy = 1;

		foreach (dir_rows[i])
			send_vote(dir_rows[i].client, dir_rows[i].kind, dir_rows[i].avg,
				dir_rows[i].inst, dir_rows[i].known, dir_rows[i].st);
		drain_votes();

		write_reg(REG_BUS, 0);
		send_vote(2, 0, 48'd5, 48'd5, 1, ST_NO_BUS);
		drain_votes();
		write_reg(REG_BUS, 1);
		write_reg(REG_PORTS, 0);
		send_vote(2, 1, 48'd6, 48'd6, 1, ST_BAD_CFG);
		drain_votes();
		write_reg(REG_PORTS, 2);
		write_reg(REG_NRT, 2);
		send_vote(4, 0, 48'd8, 48'd8, 1, ST_BAD_CFG);
		drain_votes();
		write_reg(REG_PORTS, 3);
		write_reg(REG_NRT, 1);
		write_reg(REG_DRAM, 0);
		write_reg(REG_UC, 16);
		send_vote(4, 1, '1, '1, 0, 0);
		send_vote(6, 0, 48'd3, '1, 0, 0);
		drain_votes();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_DRAM, 8); write_reg(REG_UC, 3); end
				1: begin write_reg(REG_NRT, 0); write_reg(REG_UC, 31); end
				2: begin write_reg(REG_PORTS, 2); write_reg(REG_NRT, 1);
					write_reg(REG_DRAM, 15); end
				3: begin write_reg(REG_PORTS, 1); write_reg(REG_NRT, 0);
					write_reg(REG_UC, 0); end
				4: begin write_reg(REG_PORTS, 3); write_reg(REG_NRT, 2);
					write_reg(REG_DRAM, 3); write_reg(REG_UC, 5); end
				default: begin write_reg(REG_UC, 16); write_reg(REG_NRT, 1); end
			endcase
			if (ph == 2) hold_rx = 1;
			for (int n = 0; n < 16; n++) begin
				if ($urandom_range(0, 4) == 0)
					send_vote(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 0, 0, 0, 0);
				else
					send_vote(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						rand_quota(), rand_quota(), 0, 0);
				if (ph == 4 && n == 8) wait_results();
			end
			drain_votes();
		end

		while (pending_results.size() != 0) @(posedge clk);
		wait_cycles(VOTE_CYCLES);
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
